// ===== rtl/qrpm_pkg.sv =====
package qrpm_pkg;

  // Geometry of the module store.
  localparam int MAX_SIDE  = 177;
  localparam int MEM_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int SIDE_BASE = 21;
  localparam int TIMING_COL = 6;
  localparam int BITS_PER_CW = 8;

  // Module codes held in the store.
  localparam logic [1:0] MOD_WHITE = 2'd0;
  localparam logic [1:0] MOD_BLACK = 2'd1;
  localparam logic [1:0] MOD_FREE  = 2'd2;

  // Walk position after reset (version 0).
  localparam logic [7:0] WALK_RESET_POS = 8'(SIDE_BASE - 1);

  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_PLACE   = 2'd1,
    OP_READ    = 2'd2,
    OP_RESTART = 2'd3
  } opcode_e;

  typedef enum logic [0:0] {
    REG_VERSION = 1'b0,
    REG_MASK    = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET,
    ST_READ,
    ST_RDATA,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_DONE
  } state_e;

  // Configuration seen by the controller.
  typedef struct packed {
    logic [5:0] version;
    logic [2:0] mask_pattern;
    logic [7:0] side;
  } cfg_t;

  // Symbol side, clamped to the store size.
  function automatic logic [7:0] side_of(input logic [5:0] version);
    logic [8:0] s;
    s = 9'(SIDE_BASE) + {1'b0, version, 2'b00};
    if (s > 9'(MAX_SIDE)) begin
      s = 9'(MAX_SIDE);
    end
    return s[7:0];
  endfunction

  // Store address of a module.
  function automatic logic [ADDR_W-1:0] mem_addr(input logic [7:0] row,
                                                 input logic [7:0] col);
    return ADDR_W'(row) * ADDR_W'(MAX_SIDE) + ADDR_W'(col);
  endfunction

  // Quotient by three of an 8-bit value, by reciprocal multiplication.
  function automatic logic [6:0] div3(input logic [7:0] x);
    logic [16:0] p;
    p = 17'(x) * 17'd171;
    return p[15:9];
  endfunction

  function automatic logic [1:0] mod3(input logic [7:0] x);
    logic [8:0] t;
    t = 9'(x) - 9'(div3(x)) * 9'd3;
    return t[1:0];
  endfunction

  // Reduce a value below six modulo three.
  function automatic logic [1:0] fold3(input logic [2:0] x);
    logic [2:0] t;
    t = (x >= 3'd3) ? x - 3'd3 : x;
    return t[1:0];
  endfunction

  // One when the data mask inverts the module at (r, c).
  function automatic logic mask_invert(input logic [2:0] pattern,
                                       input logic [7:0] r,
                                       input logic [7:0] c);
    logic [1:0] r3;
    logic [1:0] c3;
    logic [1:0] p3;
    logic [1:0] s3;
    logic       p2;
    logic       s2;
    logic [6:0] cq;
    logic       inv;
    r3  = mod3(r);
    c3  = mod3(c);
    cq  = div3(c);
    p3  = fold3(3'(r3 * c3 == 4'd4 ? 4'd1 : 4'(r3 * c3)));
    s3  = fold3(3'(r3) + 3'(c3));
    p2  = r[0] & c[0];
    s2  = r[0] ^ c[0];
    case (pattern)
      3'd0:    inv = ~s2;
      3'd1:    inv = ~r[0];
      3'd2:    inv = (c3 == 2'd0);
      3'd3:    inv = (s3 == 2'd0);
      3'd4:    inv = ~(r[1] ^ cq[0]);
      3'd5:    inv = ~p2 && (p3 == 2'd0);
      3'd6:    inv = ~(p2 ^ p3[0]);
      default: inv = ~(s2 ^ p3[0]);
    endcase
    return inv;
  endfunction

endpackage

// ===== rtl/qrpm_ram.sv =====
module qrpm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 2,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/qrpm_regs.sv =====
module qrpm_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output qrpm_pkg::cfg_t    cfg_o
);

  logic [5:0]         version_q;
  logic [5:0]         version_d;
  logic [2:0]         mask_q;
  logic [2:0]         mask_d;
  logic               wr_en;
  qrpm_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign idx    = qrpm_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;

  // Register write decode.
  always_comb begin
    version_d = version_q;
    mask_d    = mask_q;
    if (wr_en) begin
      unique case (idx)
        qrpm_pkg::REG_VERSION: version_d = pwdata[5:0];
        qrpm_pkg::REG_MASK:    mask_d    = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= '0;
      mask_q    <= '0;
    end else begin
      version_q <= version_d;
      mask_q    <= mask_d;
    end
  end

  // Register read mux.
  always_comb begin
    unique case (idx)
      qrpm_pkg::REG_VERSION: prdata = 32'(version_q);
      qrpm_pkg::REG_MASK:    prdata = 32'(mask_q);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o.version      = version_q;
  assign cfg_o.mask_pattern = mask_q;
  assign cfg_o.side         = qrpm_pkg::side_of(version_q);

endmodule

// ===== rtl/qrpm_ctrl.sv =====
module qrpm_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  qrpm_pkg::cfg_t              cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  opcode_i,
  input  logic [7:0]                  col_i,
  input  logic [7:0]                  row_i,
  input  logic [1:0]                  module_value_i,
  input  logic [7:0]                  codeword_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  read_value_o,
  output logic                        in_range_o,
  output logic [3:0]                  bits_placed_o,
  output logic                        walk_done_o,
  output logic                        ram_we_o,
  output logic [qrpm_pkg::ADDR_W-1:0] ram_waddr_o,
  output logic [1:0]                  ram_wdata_o,
  output logic                        ram_re_o,
  output logic [qrpm_pkg::ADDR_W-1:0] ram_raddr_o,
  input  logic [1:0]                  ram_rdata_i
);

  qrpm_pkg::state_e  state_q, state_d;
  qrpm_pkg::opcode_e op_in;
  logic [7:0] col_q, col_d, row_q, row_d;
  logic [1:0] val_q, val_d;
  logic [7:0] cw_q, cw_d;
  logic [3:0] placed_q, placed_d;
  logic       rng_q, rng_d;
  logic [1:0] rd_q, rd_d;
  logic [7:0] wcol_q, wcol_d, wrow_q, wrow_d;
  logic       up_q, up_d, left_q, left_d, fin_q, fin_d;
  logic [qrpm_pkg::ADDR_W-1:0] clr_q, clr_d;
  logic       ov_q, ov_d;
  logic [1:0] ord_q, ord_d;
  logic       orng_q, orng_d;
  logic [3:0] oplc_q, oplc_d;
  logic       odone_q, odone_d;

  logic [7:0] side;
  logic       in_sym;
  logic [7:0] a_row, a_col;
  logic [qrpm_pkg::ADDR_W-1:0] addr;
  logic       is_free;
  logic       mask_inv;

  logic [7:0] adv_col, adv_row, adv_col_m1;
  logic       adv_up, adv_left, adv_fin, at_edge;
  logic [8:0] row_p1;

  assign side   = cfg_i.side;
  assign op_in  = qrpm_pkg::opcode_e'(opcode_i);
  assign in_sym = (col_i < side) && (row_i < side);

  // One address multiplier shared by direct access and the walk.
  always_comb begin
    if (state_q == qrpm_pkg::ST_SET || state_q == qrpm_pkg::ST_READ) begin
      a_row = row_q;
      a_col = col_q;
    end else begin
      a_row = wrow_q;
      a_col = wcol_q;
    end
  end

  assign addr     = qrpm_pkg::mem_addr(a_row, a_col);
  assign is_free  = (ram_rdata_i == qrpm_pkg::MOD_FREE);
  assign mask_inv = qrpm_pkg::mask_invert(cfg_i.mask_pattern, wrow_q, wcol_q);

  // Next zigzag position: right column, left column, then one row on.
  always_comb begin
    adv_col    = wcol_q;
    adv_row    = wrow_q;
    adv_up     = up_q;
    adv_left   = left_q;
    adv_fin    = 1'b0;
    at_edge    = 1'b0;
    row_p1     = {1'b0, wrow_q} + 9'd1;
    adv_col_m1 = wcol_q - 8'd1;
    if (!left_q) begin
      adv_col  = adv_col_m1;
      adv_left = 1'b1;
    end else begin
      adv_left = 1'b0;
      if (up_q) begin
        at_edge = (wrow_q == 8'd0);
        adv_row = wrow_q - 8'd1;
      end else begin
        at_edge = (row_p1 >= {1'b0, side});
        adv_row = row_p1[7:0];
      end
      if (!at_edge) begin
        adv_col = wcol_q + 8'd1;
      end else begin
        // Turn around and move to the next column pair on the left.
        adv_row = up_q ? 8'd0 : side - 8'd1;
        adv_up  = ~up_q;
        if (wcol_q == 8'd0) begin
          adv_fin = 1'b1;
          adv_col = 8'd0;
        end else if (adv_col_m1 == 8'(qrpm_pkg::TIMING_COL)) begin
          adv_col = adv_col_m1 - 8'd1;
        end else begin
          adv_col = adv_col_m1;
        end
      end
    end
  end

  // Sequencer: next state, store accesses and result.
  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    val_d     = val_q;
    cw_d      = cw_q;
    placed_d  = placed_q;
    rng_d     = rng_q;
    rd_d      = rd_q;
    wcol_d    = wcol_q;
    wrow_d    = wrow_q;
    up_d      = up_q;
    left_d    = left_q;
    fin_d     = fin_q;
    clr_d     = clr_q;
    ov_d      = ov_q && !out_ready_i;
    ord_d     = ord_q;
    orng_d    = orng_q;
    oplc_d    = oplc_q;
    odone_d   = odone_q;
    in_ready_o  = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = addr;
    ram_wdata_o = val_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = addr;

    unique case (state_q)
      qrpm_pkg::ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = qrpm_pkg::MOD_FREE;
        if (clr_q == qrpm_pkg::ADDR_W'(qrpm_pkg::MEM_DEPTH - 1)) begin
          state_d = qrpm_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + qrpm_pkg::ADDR_W'(1);
        end
      end

      qrpm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          col_d    = col_i;
          row_d    = row_i;
          val_d    = module_value_i;
          cw_d     = codeword_i;
          placed_d = '0;
          rd_d     = '0;
          rng_d    = in_sym && (op_in == qrpm_pkg::OP_SET || op_in == qrpm_pkg::OP_READ);
          unique case (op_in)
            qrpm_pkg::OP_SET:
              state_d = in_sym ? qrpm_pkg::ST_SET : qrpm_pkg::ST_DONE;
            qrpm_pkg::OP_READ:
              state_d = in_sym ? qrpm_pkg::ST_READ : qrpm_pkg::ST_DONE;
            qrpm_pkg::OP_PLACE:
              state_d = fin_q ? qrpm_pkg::ST_DONE : qrpm_pkg::ST_WALK_RD;
            qrpm_pkg::OP_RESTART: begin
              wcol_d  = side - 8'd1;
              wrow_d  = side - 8'd1;
              up_d    = 1'b1;
              left_d  = 1'b0;
              fin_d   = 1'b0;
              state_d = qrpm_pkg::ST_DONE;
            end
            default: state_d = qrpm_pkg::ST_DONE;
          endcase
        end
      end

      qrpm_pkg::ST_SET: begin
        ram_we_o = 1'b1;
        state_d  = qrpm_pkg::ST_DONE;
      end

      qrpm_pkg::ST_READ: begin
        ram_re_o = 1'b1;
        state_d  = qrpm_pkg::ST_RDATA;
      end

      qrpm_pkg::ST_RDATA: begin
        rd_d    = ram_rdata_i;
        state_d = qrpm_pkg::ST_DONE;
      end

      qrpm_pkg::ST_WALK_RD: begin
        // A position outside the current symbol ends the walk.
        if (wcol_q >= side || wrow_q >= side) begin
          fin_d   = 1'b1;
          state_d = qrpm_pkg::ST_DONE;
        end else begin
          ram_re_o = 1'b1;
          state_d  = qrpm_pkg::ST_WALK_CHK;
        end
      end

      qrpm_pkg::ST_WALK_CHK: begin
        if (is_free) begin
          ram_we_o    = 1'b1;
          ram_wdata_o = {1'b0, cw_q[7] ^ mask_inv};
          cw_d        = {cw_q[6:0], 1'b0};
          placed_d    = placed_q + 4'd1;
        end
        wcol_d = adv_col;
        wrow_d = adv_row;
        up_d   = adv_up;
        left_d = adv_left;
        fin_d  = fin_q | adv_fin;
        if ((is_free && placed_q == 4'(qrpm_pkg::BITS_PER_CW - 1)) || adv_fin) begin
          state_d = qrpm_pkg::ST_DONE;
        end else begin
          state_d = qrpm_pkg::ST_WALK_RD;
        end
      end

      qrpm_pkg::ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ord_d   = rd_q;
          orng_d  = rng_q;
          oplc_d  = placed_q;
          odone_d = fin_q;
          state_d = qrpm_pkg::ST_IDLE;
        end
      end

      default: state_d = qrpm_pkg::ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qrpm_pkg::ST_CLEAR;
      clr_q   <= '0;
      wcol_q  <= qrpm_pkg::WALK_RESET_POS;
      wrow_q  <= qrpm_pkg::WALK_RESET_POS;
      up_q    <= 1'b1;
      left_q  <= 1'b0;
      fin_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      wcol_q  <= wcol_d;
      wrow_q  <= wrow_d;
      up_q    <= up_d;
      left_q  <= left_d;
      fin_q   <= fin_d;
      ov_q    <= ov_d;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    col_q    <= col_d;
    row_q    <= row_d;
    val_q    <= val_d;
    cw_q     <= cw_d;
    placed_q <= placed_d;
    rng_q    <= rng_d;
    rd_q     <= rd_d;
    ord_q    <= ord_d;
    orng_q   <= orng_d;
    oplc_q   <= oplc_d;
    odone_q  <= odone_d;
  end

  assign out_valid_o   = ov_q;
  assign read_value_o  = ord_q;
  assign in_range_o    = orng_q;
  assign bits_placed_o = oplc_q;
  assign walk_done_o   = odone_q;

endmodule

// ===== rtl/qr_module_placement_masker_core.sv =====
// QR module placement and masking core.
// Requests enter on the in_valid_i / in_ready_o channel: set a module, place
// a codeword along the zigzag walk, read a module, or restart the walk. Each
// request gives exactly one result on out_valid_o / out_ready_i.
// The user writes the symbol version and the mask pattern through the APB
// port only while the core is idle; the core does not enforce this. pready
// is always high. The module matrix lives in one single-port-write,
// registered-read memory of 177 x 177 two-bit entries. After reset the core
// sweeps every entry of the memory to free, one entry per cycle; in_ready_o
// stays low during the sweep while configuration writes are still taken.
// From acceptance to result: restart goes straight to the result, set writes
// the memory once, read reads it and captures the data, and place reads each
// visited position and writes it back only if it is free, until eight modules
// are placed or the walk ends. A place after the walk has finished goes straight to the result.
// One request is processed at a time. A finished result sits in an output
// register, and a stalled receiver holds the core once the next result is
// ready; the next request is accepted while a result waits.
module qr_module_placement_masker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  col_i,
  input  logic [7:0]  row_i,
  input  logic [1:0]  module_value_i,
  input  logic [7:0]  codeword_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  read_value_o,
  output logic        in_range_o,
  output logic [3:0]  bits_placed_o,
  output logic        walk_done_o
);

  qrpm_pkg::cfg_t              cfg;
  logic                        ram_we;
  logic [qrpm_pkg::ADDR_W-1:0] ram_waddr;
  logic [1:0]                  ram_wdata;
  logic                        ram_re;
  logic [qrpm_pkg::ADDR_W-1:0] ram_raddr;
  logic [1:0]                  ram_rdata;

  // Configuration registers.
  qrpm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Request sequencer and zigzag walk.
  qrpm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .col_i          (col_i),
    .row_i          (row_i),
    .module_value_i (module_value_i),
    .codeword_i     (codeword_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_value_o   (read_value_o),
    .in_range_o     (in_range_o),
    .bits_placed_o  (bits_placed_o),
    .walk_done_o    (walk_done_o),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  // Module matrix.
  qrpm_ram #(
    .DEPTH (qrpm_pkg::MEM_DEPTH),
    .WIDTH (2)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
